// ===== rtl/bfk_pkg.sv =====
// ----------------------------------------------------------------------------
// bfk_pkg: shared types and constants for the Feistel cipher block
// Field widths, modes, round count and the queue entry type.
// ----------------------------------------------------------------------------
package bfk_pkg;
  localparam int ROUNDS        = 16;
  localparam int MAX_KEY_WORDS = 18;
  localparam int P_WORDS       = 18;
  localparam int S_WORDS       = 1024;
  localparam int LAST_TABLE_IX = 1041;
  localparam int PW = $clog2(P_WORDS);
  localparam int SW = $clog2(S_WORDS);
  localparam int KW = $clog2(MAX_KEY_WORDS);
  localparam int RW = $clog2(ROUNDS + 2);

  localparam logic [1:0] MODE_LOAD_TABLE = 2'd0;
  localparam logic [1:0] MODE_LOAD_KEY   = 2'd1;
  localparam logic [1:0] MODE_EXPAND     = 2'd2;
  localparam logic [1:0] MODE_ENCRYPT    = 2'd3;

  localparam logic KIND_EXPAND_DONE = 1'b0;
  localparam logic KIND_CIPHER      = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [10:0] table_index;
    logic [31:0] load_word;
    logic [31:0] left_half;
    logic [31:0] right_half;
  } bfk_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] left_out;
    logic [31:0] right_out;
  } bfk_out_t;

  // classified command handed from front to back
  typedef struct packed {
    logic [1:0]  mode;
    logic        p_wr;
    logic        s_wr;
    logic        k_wr;
    logic [SW-1:0] addr;
    logic [31:0] word;
    logic [31:0] left;
    logic [31:0] right;
  } bfk_cmd_t;
endpackage

// ===== rtl/bfk_if.sv =====
// ----------------------------------------------------------------------------
// bfk_if: valid/ready channel interfaces
// Input, result and configuration channels.
// ----------------------------------------------------------------------------
interface bfk_in_if import bfk_pkg::*; ();
  logic    valid;
  logic    ready;
  bfk_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bfk_out_if import bfk_pkg::*; ();
  logic     valid;
  logic     ready;
  bfk_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bfk_cfg_if ();
  logic       valid;
  logic       ready;
  logic [4:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/bfk_ram.sv =====
// ----------------------------------------------------------------------------
// bfk_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module bfk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem_r[addr] <= wdata;
    rdata <= mem_r[addr];
  end
endmodule

// ===== rtl/bfk_front.sv =====
// ----------------------------------------------------------------------------
// bfk_front: input classifier and command queue
// Decodes mode and index range, queues commands two deep for the back end.
// ----------------------------------------------------------------------------
module bfk_front import bfk_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  bfk_in_if.sink   in_ch,
  output logic     cmd_valid,
  output bfk_cmd_t cmd,
  input  logic     cmd_ready
);
  bfk_cmd_t  q_r [2];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;
  bfk_cmd_t  c;
  logic      push, pop;
  logic [10:0] sidx;

  always_comb begin
    sidx          = in_ch.data.table_index - 11'(P_WORDS);
    c.mode        = in_ch.data.mode;
    c.p_wr        = (in_ch.data.mode == MODE_LOAD_TABLE) &&
                    (in_ch.data.table_index < 11'(P_WORDS));
    c.s_wr        = (in_ch.data.mode == MODE_LOAD_TABLE) &&
                    (in_ch.data.table_index >= 11'(P_WORDS)) &&
                    (in_ch.data.table_index <= 11'(LAST_TABLE_IX));
    c.k_wr        = (in_ch.data.mode == MODE_LOAD_KEY) &&
                    (in_ch.data.table_index < 11'(MAX_KEY_WORDS));
    c.addr        = c.s_wr ? sidx[SW-1:0] : SW'(in_ch.data.table_index[4:0]);
    c.word        = in_ch.data.load_word;
    c.left        = in_ch.data.left_half;
    c.right       = in_ch.data.right_half;
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push      = in_ch.valid && in_ch.ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= c;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

// ===== rtl/bfk_back.sv =====
// ----------------------------------------------------------------------------
// bfk_back: table stores, round engine and key expansion sequencer
// P and key in flops, four S-boxes in RAMs; each round has an S-box read state and a combine state.
// ----------------------------------------------------------------------------
module bfk_back import bfk_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic [4:0] kwc,
  input  logic     cmd_valid,
  input  bfk_cmd_t cmd,
  output logic     cmd_ready,
  bfk_out_if.source out_ch
);
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_XKEY  = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_FN    = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]  st_r;
  logic [31:0] p_r [P_WORDS];
  logic [31:0] k_r [MAX_KEY_WORDS];
  logic [31:0] l_r, r_r;
  logic [RW-1:0] rnd_r;
  logic        exp_r;
  logic [SW:0] fill_r;    // next P/S pair slot during expansion
  logic [PW-1:0] xi_r;
  logic [KW-1:0] ki_r;
  logic [4:0]  n_eff;
  logic        out_v_r;
  bfk_out_t    out_r;

  logic        s_we [4];
  logic [7:0]  s_ad [4];
  logic [31:0] s_wd [4];
  logic [31:0] s_rd [4];
  logic [31:0] f;
  logic [31:0] lx;
  logic [31:0] fl, fr;

  assign n_eff = (kwc == 5'd0) ? 5'd1 :
                 (kwc > 5'(MAX_KEY_WORDS)) ? 5'(MAX_KEY_WORDS) : kwc;
  assign lx = l_r ^ p_r[rnd_r[PW-1:0]];
  assign f  = ((s_rd[0] + s_rd[1]) ^ s_rd[2]) + s_rd[3];
  assign fl = r_r ^ p_r[ROUNDS + 1];
  assign fr = l_r ^ p_r[ROUNDS];

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      s_we[b] = 1'b0;
      s_wd[b] = fl;
      s_ad[b] = lx[31-8*b -: 8];
    end
    if (cmd_valid && cmd_ready && cmd.s_wr) begin
      s_we[cmd.addr[SW-1:8]] = 1'b1;
      for (int b = 0; b < 4; b++) begin
        s_ad[b] = cmd.addr[7:0];
        s_wd[b] = cmd.word;
      end
    end
  end

  // S-box write in expansion is handled with sx signals below
  logic [SW-1:0] sx;
  logic sx_we0, sx_we1;
  assign sx     = SW'(fill_r - (SW+1)'(P_WORDS));
  assign sx_we0 = (st_r == ST_FIN) && exp_r && (fill_r >= (SW+1)'(P_WORDS));
  assign sx_we1 = (st_r == ST_OUT) && exp_r && (fill_r >= (SW+1)'(P_WORDS));

  logic        m_we [4];
  logic [7:0]  m_ad [4];
  logic [31:0] m_wd [4];
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      m_we[b] = s_we[b];
      m_ad[b] = s_ad[b];
      m_wd[b] = s_wd[b];
    end
    if (sx_we0) begin
      m_we[sx[SW-1:8]] = 1'b1;
      m_ad[sx[SW-1:8]] = sx[7:0];
      m_wd[sx[SW-1:8]] = fl;
    end else if (sx_we1) begin
      m_we[sx[SW-1:8]] = 1'b1;
      m_ad[sx[SW-1:8]] = sx[7:0] | 8'd1;
      m_wd[sx[SW-1:8]] = r_r;
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_sbox
    bfk_ram #(.WIDTH(32), .DEPTH(256)) u_sbox (
      .clk(clk), .we(m_we[b]), .addr(m_ad[b]), .wdata(m_wd[b]), .rdata(s_rd[b])
    );
  end

  assign cmd_ready    = (st_r == ST_IDLE) && !out_v_r;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      out_v_r <= 1'b0;
      exp_r   <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_v_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: if (cmd_valid && cmd_ready) begin
          if (cmd.p_wr) p_r[cmd.addr[PW-1:0]] <= cmd.word;
          if (cmd.k_wr) k_r[cmd.addr[KW-1:0]] <= cmd.word;
          l_r   <= cmd.left;
          r_r   <= cmd.right;
          rnd_r <= '0;
          exp_r <= (cmd.mode == MODE_EXPAND);
          xi_r  <= '0;
          ki_r  <= '0;
          fill_r <= '0;
          if (cmd.mode == MODE_EXPAND) st_r <= ST_XKEY;
          else if (cmd.mode == MODE_ENCRYPT) st_r <= ST_RD;
        end
        ST_XKEY: begin
          p_r[xi_r] <= p_r[xi_r] ^ k_r[ki_r];
          ki_r <= (5'(ki_r) + 5'd1 == n_eff) ? '0 : ki_r + KW'(1);
          xi_r <= xi_r + PW'(1);
          if (xi_r == PW'(P_WORDS - 1)) begin
            l_r <= '0;
            r_r <= '0;
            st_r <= ST_RD;
          end
        end
        ST_RD: begin
          l_r  <= lx;   // S reads address from lx this cycle
          st_r <= ST_FN;
        end
        ST_FN: begin
          l_r   <= r_r ^ f;
          r_r   <= l_r;
          rnd_r <= rnd_r + RW'(1);
          st_r  <= (rnd_r == RW'(ROUNDS - 1)) ? ST_FIN : ST_RD;
        end
        ST_FIN: begin
          // undo last swap and whiten: left = r^P17, right = l^P16
          l_r <= fl;
          r_r <= fr;
          if (exp_r && fill_r < (SW+1)'(P_WORDS)) begin
            p_r[fill_r[PW-1:0]]       <= fl;
            p_r[fill_r[PW-1:0] + 1'b1] <= fr;
          end
          st_r <= ST_OUT;
        end
        default: begin // ST_OUT
          rnd_r <= '0;
          if (exp_r && fill_r != (SW+1)'(P_WORDS + S_WORDS - 2)) begin
            fill_r <= fill_r + (SW+1)'(2);
            st_r   <= ST_RD;
          end else if (!out_v_r) begin
            out_v_r <= 1'b1;
            out_r.result_kind <= exp_r ? KIND_EXPAND_DONE : KIND_CIPHER;
            out_r.left_out    <= exp_r ? 32'd0 : l_r;
            out_r.right_out   <= exp_r ? 32'd0 : r_r;
            st_r <= ST_IDLE;
          end
        end
      endcase
    end
  end
endmodule

// ===== rtl/feistel_block_cipher_with_key_expansion.sv =====
// ----------------------------------------------------------------------------
// feistel_block_cipher_with_key_expansion: 64-bit Feistel cipher top level
// Front classifier, two-entry command queue, table and round back end.
// ----------------------------------------------------------------------------
// An encryption runs 16 rounds in the back end: each round reads the four
// S-box RAMs (registered read) and combines the results in the next cycle.
// A key expansion mixes the key words into the 18 P entries and then runs
// 521 chained encryptions that refill P and the S-boxes. Up to two commands
// queue ahead of the back end.
module feistel_block_cipher_with_key_expansion import bfk_pkg::*; (
  input logic clk,
  input logic rst_n,
  bfk_in_if.sink    in_ch,
  bfk_out_if.source out_ch,
  bfk_cfg_if.sink   cfg_ch
);
  logic [4:0] kwc_val_r;
  logic       cmd_valid, cmd_ready;
  bfk_cmd_t   cmd;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) kwc_val_r <= 5'd2;
    else if (cfg_ch.valid && cfg_ch.ready) kwc_val_r <= cfg_ch.data;
  end

  bfk_front u_front (
    .clk, .rst_n, .in_ch, .cmd_valid, .cmd, .cmd_ready
  );

  bfk_back u_back (
    .clk, .rst_n, .kwc(kwc_val_r), .cmd_valid, .cmd, .cmd_ready,
    .out_ch
  );

`ifndef SYNTH
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result dropped while stalled");
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.result_kind == KIND_EXPAND_DONE |->
      out_ch.data.left_out == 32'd0 && out_ch.data.right_out == 32'd0)
    else $error("expansion done carries data");
`endif
endmodule
